[hdl/vebd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vebd_pkg
// Shared types for the escape byte decoder: group tracking state and the
// emit command passed from the front end to the back end.
// ----------------------------------------------------------------------------
package vebd_pkg;

  // bytes held for the escape group being assembled
  typedef enum logic [1:0] {
    GRP_IDLE  = 2'd0,
    GRP_ONE   = 2'd1,
    GRP_TWO   = 2'd2,
    GRP_THREE = 2'd3
  } grp_state_e;

  // up to four bytes to send out, oldest in bytes[0]
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            fin;
  } cmd_t;

endpackage

[hdl/vebd_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vebd_front
// Takes one encoded byte per transfer, tracks open escape groups and turns
// each completed run into an emit command of one to four bytes.
// ----------------------------------------------------------------------------
module vebd_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     in_byte_i,
  input  logic           is_final_i,
  output logic           cmd_valid_o,
  output vebd_pkg::cmd_t cmd_o
);
  import vebd_pkg::*;

  localparam logic [7:0] Bslash   = 8'h5c;
  localparam logic [7:0] ChrM     = 8'h4d;
  localparam logic [7:0] ChrDash  = 8'h2d;
  localparam logic [7:0] ChrCaret = 8'h5e;
  localparam logic [3:0] DigitHi  = 4'h3;
  localparam logic [7:0] CtrlOfs  = 8'h40;
  localparam logic [7:0] MetaBit  = 8'h80;

  grp_state_e state_q, state_d;
  logic [7:0] a_q, a_d;
  logic [7:0] c_q, c_d;
  logic [7:0] dec_byte;
  logic       dec_known;

  // next state
  always_comb begin
    state_d = state_q;
    if (accept_i) begin
      unique case (state_q)
        GRP_IDLE: begin
          if (in_byte_i == Bslash && !is_final_i) state_d = GRP_ONE;
        end
        GRP_ONE: begin
          state_d = is_final_i ? GRP_IDLE : GRP_TWO;
        end
        GRP_TWO: begin
          state_d = is_final_i ? GRP_IDLE : GRP_THREE;
        end
        GRP_THREE: begin
          state_d = GRP_IDLE;
        end
        default: state_d = GRP_IDLE;
      endcase
    end
  end

  // group decode on the completing byte
  always_comb begin
    dec_known = 1'b1;
    priority if (a_q == ChrM && c_q == ChrCaret) begin
      dec_byte = {1'b0, in_byte_i[6:0]} + CtrlOfs;
    end else if (a_q == ChrM && c_q == ChrDash) begin
      dec_byte = in_byte_i | MetaBit;
    end else if (a_q[7:4] == DigitHi && c_q[7:4] == DigitHi) begin
      dec_byte = {a_q[1:0], c_q[2:0], in_byte_i[2:0]};
    end else begin
      dec_byte  = in_byte_i;
      dec_known = 1'b0;
    end
  end

  // outputs
  always_comb begin
    cmd_valid_o    = 1'b0;
    cmd_o.bytes    = {in_byte_i, in_byte_i, in_byte_i, in_byte_i};
    cmd_o.last_idx = 2'd0;
    cmd_o.fin      = is_final_i;
    a_d            = a_q;
    c_d            = c_q;
    unique case (state_q)
      GRP_IDLE: begin
        cmd_valid_o = !(in_byte_i == Bslash && !is_final_i);
      end
      GRP_ONE: begin
        a_d            = in_byte_i;
        cmd_valid_o    = is_final_i;
        cmd_o.bytes[0] = Bslash;
        cmd_o.last_idx = 2'd1;
      end
      GRP_TWO: begin
        c_d            = in_byte_i;
        cmd_valid_o    = is_final_i;
        cmd_o.bytes[0] = Bslash;
        cmd_o.bytes[1] = a_q;
        cmd_o.last_idx = 2'd2;
      end
      GRP_THREE: begin
        cmd_valid_o = 1'b1;
        if (dec_known) begin
          cmd_o.bytes[0] = dec_byte;
        end else begin
          cmd_o.bytes[0] = Bslash;
          cmd_o.bytes[1] = a_q;
          cmd_o.bytes[2] = c_q;
          cmd_o.last_idx = 2'd3;
        end
      end
      default: cmd_valid_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GRP_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      a_q <= a_d;
      c_q <= c_d;
    end
  end

endmodule

[hdl/vebd_cmd_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vebd_cmd_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module vebd_cmd_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  vebd_pkg::cmd_t wr_data_i,
  input  logic           rd_i,
  output vebd_pkg::cmd_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);
  import vebd_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (do_rd) rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (do_wr && !do_rd) cnt_d = cnt_q + 1'b1;
    else if (do_rd && !do_wr) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) mem_q[wr_ptr_q] <= wr_data_i;
  end

endmodule

[hdl/vebd_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vebd_back
// Expands queued emit commands into single decoded bytes, one per cycle
// while the result register is free or being popped, into that register.
// ----------------------------------------------------------------------------
module vebd_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_empty_i,
  input  vebd_pkg::cmd_t cmd_i,
  output logic           cmd_rd_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_byte_o,
  output logic           run_last_o,
  output logic           message_end_o
);
  import vebd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q;
  logic       last_q, end_q;
  logic       take, at_last;

  // result register is free or being drained this cycle
  assign take    = !cmd_empty_i && (!valid_q || pop_i);
  assign at_last = (idx_q == cmd_i.last_idx);
  assign cmd_rd_o = take && at_last;

  always_comb begin
    idx_d   = idx_q;
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
      idx_d   = at_last ? 2'd0 : idx_q + 2'd1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= cmd_i.bytes[idx_q];
      last_q <= at_last;
      end_q  <= at_last && cmd_i.fin;
    end
  end

  assign empty_o       = !valid_q;
  assign out_byte_o    = byte_q;
  assign run_last_o    = last_q;
  assign message_end_o = end_q;

endmodule

[hdl/vis_escape_byte_decoder.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vis_escape_byte_decoder
// Undoes vis-style backslash escapes in a byte stream, one byte per transfer.
// ----------------------------------------------------------------------------
// One encoded byte is taken per cycle while full is low. A plain byte gives
// one result; a backslash opens a four-byte group that gives nothing until it
// completes, then one decoded byte or, for an unknown form or a message that
// ends inside the group, the held bytes copied out. Results leave at one per
// cycle, while pop drains them, from a single output register; a result is
// queued at the transfer that caused it and moved into the output register
// once that register is free or being popped. The output side is the limit:
// a copied-out group occupies it for up to four bytes, during which the
// CmdDepth-entry command queue takes further input and full rises once it
// holds CmdDepth commands.
module vis_escape_byte_decoder #(
  parameter int unsigned CmdDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       is_final_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       message_end_o
);
  import vebd_pkg::*;

  logic accept;
  logic cmd_valid;
  cmd_t cmd_wr;
  cmd_t cmd_head;
  logic cmd_rd;
  logic cmd_empty;

  assign accept = push && !full;

  vebd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .in_byte_i   (in_byte_i),
    .is_final_i  (is_final_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_wr)
  );

  vebd_cmd_fifo #(
    .Depth (CmdDepth)
  ) u_cmd_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (accept && cmd_valid),
    .wr_data_i (cmd_wr),
    .rd_i      (cmd_rd),
    .rd_data_o (cmd_head),
    .full_o    (full),
    .empty_o   (cmd_empty)
  );

  vebd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_empty_i   (cmd_empty),
    .cmd_i         (cmd_head),
    .cmd_rd_o      (cmd_rd),
    .pop_i         (pop),
    .empty_o       (empty),
    .out_byte_o    (out_byte_o),
    .run_last_o    (run_last_o),
    .message_end_o (message_end_o)
  );

  // while a command is queued, the output register holds a byte by the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_empty |=> !empty)
    else $error("queued command left output register idle");

  // message end only marks the last byte of a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && message_end_o) |-> run_last_o)
    else $error("message end without run last");

  // expansion index stays inside the head command
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_empty |-> (u_back.idx_q <= cmd_head.last_idx))
    else $error("expansion index beyond command length");

endmodule
